[hdl/pcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg
// Types and fixed widths shared by the correlation unit's front end, job
// queue and arithmetic back end.
// ----------------------------------------------------------------------------
package pcc_pkg;

    // Fixed widths of the running state (sized for the largest series)
    localparam int CNT_W  = 13;
    localparam int SX_W   = 29;
    localparam int SXX_W  = 44;
    localparam int SXY_W  = 45;
    // Centered sums N*S - S*S and their magnitudes
    localparam int DIFF_W = 56;
    localparam int MAG_W  = 55;
    // Wide products vx*vy and cov*cov
    localparam int PROD_W = 2 * MAG_W;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_VAR = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
        logic               last_pair;
    } pcc_in_t;

    typedef struct packed {
        logic signed [15:0] correlation;
        status_t            status;
    } pcc_out_t;

    // One finished series, handed from the front end to the back end
    typedef struct packed {
        logic [CNT_W-1:0]        pair_count;
        logic signed [SX_W-1:0]  sum_x;
        logic signed [SX_W-1:0]  sum_y;
        logic [SXX_W-1:0]        sum_xx;
        logic [SXX_W-1:0]        sum_yy;
        logic signed [SXY_W-1:0] sum_xy;
        logic                    overflow;
    } pcc_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pcc_qstat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERM_MUL,
        ST_TERM_SUB,
        ST_CHECK,
        ST_MUL_VV,
        ST_MUL_COV,
        ST_DIV_INIT,
        ST_DIV,
        ST_SQRT,
        ST_FINISH
    } back_state_t;

endpackage

[hdl/pearson_correlation_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pearson_correlation_unit
// Pearson correlation of paired signed series, result in signed Q1.FRAC_BITS.
//
//   channel   direction   handshake                     payload
//   pair      in          pair_valid / pair_ready       pcc_in_t  (x, y, last)
//   result    out         result_valid / result_ready   pcc_out_t (r, status)
//
// Flow: the front end takes one pair every cycle, except that a closing pair
//   waits while the queue is full. Each closing pair queues one job; the back
//   end works through it with two 55-step serial multiplies, a 2*FRAC_BITS+2
//   step divide and a FRAC_BITS+2 step square root.
// Reset: rst_n clears sums, queue and sequencer; no clearing pass.
// Stalls: a closing pair waits only while both queue slots are taken; the
//   result register holds until taken while the front end keeps running.
// ----------------------------------------------------------------------------
module pearson_correlation_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_PAIRS   = 4096,
    parameter int FRAC_BITS   = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pair_valid,
    output logic              pair_ready,
    input  pcc_pkg::pcc_in_t  pair,
    output logic              result_valid,
    input  logic              result_ready,
    output pcc_pkg::pcc_out_t result
);
    import pcc_pkg::*;

    // Queue handshakes between the accumulator and the sequencer
    logic       push, pop;
    pcc_job_t   push_data, pop_data;
    pcc_qstat_t qstat;

    // Front: accumulate sums, one pair per cycle unless a closing pair meets a full queue
    pcc_front #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .MAX_PAIRS  (MAX_PAIRS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair_valid(pair_valid),
        .pair_ready(pair_ready),
        .pair      (pair),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple: two finished series may wait here
    pcc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .pop_data (pop_data),
        .qstat    (qstat)
    );

    // Back: centered sums, products, divide and square root, one series at a time
    pcc_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .qstat       (qstat),
        .job         (pop_data),
        .pop         (pop),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    // Never push a series into a full queue
    a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("job pushed into full queue");

    // Never pop an empty queue
    a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("job popped from empty queue");

    // Flagged results carry a zero coefficient
    a_flag_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != STATUS_OK) |-> (result.correlation == '0))
        else $error("flagged result with nonzero correlation");

endmodule

[hdl/pcc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_front
// Accumulates count and running sums, one pair per cycle while a closing pair
// finds a free queue slot; hands each finished series to the job queue.
// ----------------------------------------------------------------------------
module pcc_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_PAIRS   = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pair_valid,
    output logic               pair_ready,
    input  pcc_pkg::pcc_in_t   pair,
    input  pcc_pkg::pcc_qstat_t qstat,
    output logic               push,
    output pcc_pkg::pcc_job_t  push_data
);
    import pcc_pkg::*;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SX_W-1:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic [SXX_W-1:0]        sxx_reg, sxx_next, syy_reg, syy_next;
    logic signed [SXY_W-1:0] sxy_reg, sxy_next;
    logic                    ovf_reg, ovf_next;

    logic signed [SAMPLE_BITS-1:0] x_raw, y_raw;
    logic signed [15:0]            x_s, y_s;
    logic signed [31:0]            xx, yy, xy;
    logic                          accept, full_count;

    assign x_raw = pair.x_sample[SAMPLE_BITS-1:0];
    assign y_raw = pair.y_sample[SAMPLE_BITS-1:0];
    assign x_s   = 16'(x_raw);
    assign y_s   = 16'(y_raw);
    assign xx    = x_s * x_s;
    assign yy    = y_s * y_s;
    assign xy    = x_s * y_s;

    // Stall only a closing pair when no queue slot is free
    assign pair_ready = !qstat.full || !pair.last_pair;
    assign accept     = pair_valid && pair_ready;
    assign full_count = (count_reg == CNT_W'(MAX_PAIRS));

    always_comb
    begin
        count_next = count_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        sxx_next   = sxx_reg;
        syy_next   = syy_reg;
        sxy_next   = sxy_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (full_count)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                sx_next    = sx_reg + SX_W'(x_s);
                sy_next    = sy_reg + SX_W'(y_s);
                sxx_next   = sxx_reg + SXX_W'($unsigned(xx));
                syy_next   = syy_reg + SXX_W'($unsigned(yy));
                sxy_next   = sxy_reg + SXY_W'(xy);
            end
        end
    end

    assign push = accept && pair.last_pair;

    always_comb
    begin
        push_data.pair_count = count_next;
        push_data.sum_x      = sx_next;
        push_data.sum_y      = sy_next;
        push_data.sum_xx     = sxx_next;
        push_data.sum_yy     = syy_next;
        push_data.sum_xy     = sxy_next;
        push_data.overflow   = ovf_next;
    end

    // Clear the sums after a closing pair for the next series
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (push)
        begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            sxx_reg   <= sxx_next;
            syy_reg   <= syy_next;
            sxy_reg   <= sxy_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

[hdl/pcc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pcc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pcc_pkg::pcc_job_t   push_data,
    input  logic                pop,
    output pcc_pkg::pcc_job_t   pop_data,
    output pcc_pkg::pcc_qstat_t qstat
);
    import pcc_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    pcc_job_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg, rd_reg;
    logic [PTR_W:0]     fill_reg;

    assign qstat.full  = (fill_reg == (PTR_W+1)'(DEPTH));
    assign qstat.empty = (fill_reg == '0);
    assign pop_data    = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/pcc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_back
// Sequenced arithmetic for one series: centered sums, two serial wide
// products, restoring divide and digit-by-digit square root.
// ----------------------------------------------------------------------------
module pcc_back #(
    parameter int FRAC_BITS = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pcc_pkg::pcc_qstat_t qstat,
    input  pcc_pkg::pcc_job_t   job,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_ready,
    output pcc_pkg::pcc_out_t   result
);
    import pcc_pkg::*;

    localparam int SHIFT  = 2 * FRAC_BITS + 2;
    localparam int QUOT_W = SHIFT + 1;
    localparam int ROOT_W = FRAC_BITS + 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = FRAC_BITS + 5;
    localparam int STEP_W = $clog2(MAG_W + 1);
    localparam int P1_W   = CNT_W + 1 + SXY_W;
    localparam int P2_W   = 2 * SX_W;
    localparam logic [ROOT_W-1:0] M_MAX = ROOT_W'((1 << FRAC_BITS) - 1);

    back_state_t              state_reg, state_next;
    pcc_job_t                 job_reg, job_next;
    logic [1:0]               term_reg, term_next;
    logic signed [P1_W-1:0]   p1_reg, p1_next;
    logic signed [P2_W-1:0]   p2_reg, p2_next;
    logic signed [DIFF_W-1:0] cov_reg, cov_next, vx_reg, vx_next, vy_reg, vy_next;
    status_t                  status_reg, status_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [PROD_W-1:0]        acc_reg, acc_next, mca_reg, mca_next;
    logic [MAG_W-1:0]         mcb_reg, mcb_next;
    logic [PROD_W-1:0]        vv_reg, vv_next, rem_reg, rem_next;
    logic [QUOT_W-1:0]        quot_reg, quot_next;
    logic [RAD_W-1:0]         rad_reg, rad_next;
    logic [REM_W-1:0]         srem_reg, srem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic                     res_valid_reg, res_valid_next;
    pcc_out_t                 res_reg, res_next;

    logic signed [CNT_W:0]    n_s;
    logic signed [SXY_W-1:0]  op_big;
    logic signed [SX_W-1:0]   op_a, op_b;
    logic signed [P1_W-1:0]   prod1, diff_full;
    logic signed [P2_W-1:0]   prod2;
    logic [PROD_W-1:0]        acc_add, rem_dbl;
    logic signed [DIFF_W-1:0] cov_abs;
    logic                     div_bit;
    logic [REM_W-1:0]         sq_rem, sq_trial;
    logic [QUOT_W-1:0]        quot_shift;
    logic [ROOT_W:0]          root_inc;
    logic [ROOT_W-1:0]        mag;
    logic signed [15:0]       corr;

    // Operand select for the three centered sums
    always_comb
    begin
        n_s = $signed({1'b0, job_reg.pair_count});
        case (term_reg)
            2'd0:
            begin
                op_big = job_reg.sum_xy;
                op_a   = job_reg.sum_x;
                op_b   = job_reg.sum_y;
            end
            2'd1:
            begin
                op_big = $signed({1'b0, job_reg.sum_xx});
                op_a   = job_reg.sum_x;
                op_b   = job_reg.sum_x;
            end
            default:
            begin
                op_big = $signed({1'b0, job_reg.sum_yy});
                op_a   = job_reg.sum_y;
                op_b   = job_reg.sum_y;
            end
        endcase
    end

    assign prod1      = n_s * op_big;
    assign prod2      = op_a * op_b;
    assign diff_full  = p1_reg - P1_W'(p2_reg);
    assign acc_add    = mcb_reg[0] ? acc_reg + mca_reg : acc_reg;
    assign cov_abs    = (cov_reg < 0) ? -cov_reg : cov_reg;
    assign rem_dbl    = {rem_reg[PROD_W-2:0], 1'b0};
    assign div_bit    = (rem_dbl >= vv_reg);
    assign quot_shift = {quot_reg[QUOT_W-2:0], div_bit};
    assign sq_rem     = {srem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign sq_trial   = REM_W'({root_reg, 2'b01});
    assign root_inc   = (ROOT_W+1)'(root_reg) + 1'b1;
    assign mag        = root_inc[ROOT_W:1];

    always_comb
    begin
        if (cov_reg < 0)
        begin
            corr = -16'(mag);
        end
        else if (mag > M_MAX)
        begin
            corr = 16'(M_MAX);
        end
        else
        begin
            corr = 16'(mag);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        term_next      = term_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        cov_next       = cov_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        status_next    = status_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        mca_next       = mca_reg;
        mcb_next       = mcb_reg;
        vv_next        = vv_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !result_ready;
        pop            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop       = 1'b1;
                    job_next  = job;
                    term_next = 2'd0;
                    if (job.overflow)
                    begin
                        status_next = STATUS_OVERFLOW;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        state_next  = ST_TERM_MUL;
                    end
                end
            end
            ST_TERM_MUL:
            begin
                p1_next    = prod1;
                p2_next    = prod2;
                state_next = ST_TERM_SUB;
            end
            ST_TERM_SUB:
            begin
                case (term_reg)
                    2'd0:    cov_next = DIFF_W'(diff_full);
                    2'd1:    vx_next  = DIFF_W'(diff_full);
                    default: vy_next  = DIFF_W'(diff_full);
                endcase
                if (term_reg == 2'd2)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    term_next  = term_reg + 1'b1;
                    state_next = ST_TERM_MUL;
                end
            end
            ST_CHECK:
            begin
                if (vx_reg <= 0 || vy_reg <= 0)
                begin
                    status_next = STATUS_ZERO_VAR;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    acc_next   = '0;
                    mca_next   = PROD_W'(vx_reg[MAG_W-1:0]);
                    mcb_next   = vy_reg[MAG_W-1:0];
                    step_next  = '0;
                    state_next = ST_MUL_VV;
                end
            end
            ST_MUL_VV:
            begin
                acc_next  = acc_add;
                mca_next  = {mca_reg[PROD_W-2:0], 1'b0};
                mcb_next  = mcb_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MAG_W - 1))
                begin
                    vv_next    = acc_add;
                    acc_next   = '0;
                    mca_next   = PROD_W'(cov_abs[MAG_W-1:0]);
                    mcb_next   = cov_abs[MAG_W-1:0];
                    step_next  = '0;
                    state_next = ST_MUL_COV;
                end
            end
            ST_MUL_COV:
            begin
                acc_next  = acc_add;
                mca_next  = {mca_reg[PROD_W-2:0], 1'b0};
                mcb_next  = mcb_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MAG_W - 1))
                begin
                    rem_next   = acc_add;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                // Integer part of cov^2 / vv is 0 or 1
                if (rem_reg >= vv_reg)
                begin
                    rem_next  = rem_reg - vv_reg;
                    quot_next = QUOT_W'(1);
                end
                else
                begin
                    quot_next = '0;
                end
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = div_bit ? rem_dbl - vv_reg : rem_dbl;
                quot_next = quot_shift;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SHIFT - 1))
                begin
                    rad_next   = RAD_W'(quot_shift);
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sq_rem >= sq_trial)
                begin
                    srem_next = sq_rem - sq_trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = sq_rem;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold until the output register is free
                if (!res_valid_reg || result_ready)
                begin
                    res_next.status      = status_reg;
                    res_next.correlation = (status_reg == STATUS_OK) ? corr : '0;
                    res_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            term_reg      <= '0;
            step_reg      <= '0;
            status_reg    <= STATUS_OK;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            term_reg      <= term_next;
            step_reg      <= step_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        cov_reg  <= cov_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        acc_reg  <= acc_next;
        mca_reg  <= mca_next;
        mcb_reg  <= mcb_next;
        vv_reg   <= vv_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        res_reg  <= res_next;
    end

endmodule
